### design/sta_pkg.sv
// Shared types and constants for the session table with aging.
// Holds the operation and status codes, the sequencer states and the table entry layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sta_pkg;

    localparam int KEY_W  = 32;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SWEEP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_NOT_FOUND = 3'd0,
        ST_HIT       = 3'd1,
        ST_REFRESHED = 3'd2,
        ST_INSERTED  = 3'd3,
        ST_FULL      = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_SWEPT     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_WALK   = 2'd2,
        S_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] login;
    } entry_t;

endpackage

`default_nettype wire

### design/session_table_with_aging.sv
// Top level of the session table with aging: table memory, walk sequencer and
// the shared key compare and age subtract/compare unit.
// Depends on sta_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A command is taken at a rising edge where start is high and busy is low; operation,
// address_key and current_time are sampled then. The sequencer walks the table one slot
// per cycle through a single registered memory read port, and one compare/subtract unit
// judges each entry (key match, age against the timeout). Lookup, add and remove stop
// at the first slot that decides them; sweep and misses walk all TABLE_ENTRIES slots.
// After the walk the finish state writes an inserted entry and registers the result.
// The result appears on status and slot for exactly one cycle with done high. busy drops in
// the cycle where done is shown, so a new command can be taken then but not while the last
// one is still walking. The receiver cannot hold off a result. The timeout register is
// written over the cfg channel (cfg_ready is always high); write it only while the block is
// idle. After reset the table is cleared one slot per cycle, which keeps busy high until
// every slot is cleared; the timeout resets to 300.
module session_table_with_aging #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] address_key,
    input  wire logic [31:0] current_time,
    output logic             done,
    output logic [2:0]       status,
    output logic [3:0]       slot,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int EXT_W = IDX_W + sta_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    sta_pkg::entry_t mem [TABLE_ENTRIES];

    sta_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    sta_pkg::op_t     op_reg, op_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      now_reg, now_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [31:0]      timeout_reg;
    logic             done_reg, done_next;
    sta_pkg::status_t status_reg, status_next;
    logic [IDX_W-1:0] slot_idx_reg, slot_idx_next;

    sta_pkg::entry_t  rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    sta_pkg::entry_t  wr_data;

    logic             match;
    logic             live;
    logic [31:0]      age;
    logic [EXT_W-1:0] slot_ext;

    // Shared unit: key compare plus modulo 2^32 age and timeout compare.
    assign match = rd_data_reg.valid && (rd_data_reg.key == key_reg);
    assign age   = now_reg - rd_data_reg.login;
    assign live  = age < timeout_reg;

    assign busy      = (state_reg != sta_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign status    = status_reg;
    assign slot_ext  = EXT_W'(slot_idx_reg);
    assign slot      = slot_ext[sta_pkg::SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sta_pkg::S_CLEAR;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= sta_pkg::ST_NOT_FOUND;
            timeout_reg <= sta_pkg::TIMEOUT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            hit_reg    <= hit_next;
            free_reg   <= free_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        now_reg      <= now_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        slot_idx_reg <= slot_idx_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        now_next      = now_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        slot_idx_next = slot_idx_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = '0;

        unique case (state_reg)
            sta_pkg::S_CLEAR:
            begin
                wr_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = sta_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            sta_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next    = sta_pkg::op_t'(operation);
                    key_next   = address_key;
                    now_next   = current_time;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    idx_next   = '0;
                    state_next = sta_pkg::S_WALK;
                end
            end

            sta_pkg::S_WALK:
            begin
                // rd_data_reg holds slot idx_reg; fetch the next slot meanwhile.
                rd_addr = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;
                unique case (op_reg)
                    sta_pkg::OP_LOOKUP, sta_pkg::OP_ADD:
                    begin
                        if (match && live)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                            if (op_reg == sta_pkg::OP_ADD)
                            begin
                                wr_en   = 1'b1;
                                wr_data = '{valid: 1'b1, key: key_reg, login: now_reg};
                            end
                        end
                        else if (!rd_data_reg.valid || match)
                        begin
                            // An expired match is dropped and becomes a free slot.
                            wr_en = match;
                            if (!free_reg)
                            begin
                                free_next     = 1'b1;
                                free_idx_next = idx_reg;
                            end
                        end
                    end
                    sta_pkg::OP_REMOVE:
                    begin
                        if (match)
                        begin
                            wr_en        = 1'b1;
                            hit_next     = 1'b1;
                            hit_idx_next = idx_reg;
                        end
                    end
                    sta_pkg::OP_SWEEP:
                    begin
                        wr_en = rd_data_reg.valid && !live;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
                if (hit_next || idx_reg == LAST_IDX)
                begin
                    state_next = sta_pkg::S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            sta_pkg::S_FINISH:
            begin
                done_next     = 1'b1;
                slot_idx_next = '0;
                state_next    = sta_pkg::S_IDLE;
                unique case (op_reg)
                    sta_pkg::OP_LOOKUP:
                    begin
                        status_next   = hit_reg ? sta_pkg::ST_HIT : sta_pkg::ST_NOT_FOUND;
                        slot_idx_next = hit_reg ? hit_idx_reg : '0;
                    end
                    sta_pkg::OP_ADD:
                    begin
                        if (hit_reg)
                        begin
                            status_next   = sta_pkg::ST_REFRESHED;
                            slot_idx_next = hit_idx_reg;
                        end
                        else if (free_reg)
                        begin
                            status_next   = sta_pkg::ST_INSERTED;
                            slot_idx_next = free_idx_reg;
                            wr_en         = 1'b1;
                            wr_addr       = free_idx_reg;
                            wr_data       = '{valid: 1'b1, key: key_reg, login: now_reg};
                        end
                        else
                        begin
                            status_next = sta_pkg::ST_FULL;
                        end
                    end
                    sta_pkg::OP_REMOVE:
                    begin
                        status_next   = hit_reg ? sta_pkg::ST_REMOVED : sta_pkg::ST_NOT_FOUND;
                        slot_idx_next = hit_reg ? hit_idx_reg : '0;
                    end
                    sta_pkg::OP_SWEEP:
                    begin
                        status_next = sta_pkg::ST_SWEPT;
                    end
                    default:
                    begin
                        status_next = sta_pkg::ST_NOT_FOUND;
                    end
                endcase
            end

            default:
            begin
                state_next = sta_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/sta_checker.sv
// Port-level checks for the session table with aging, bound to the top level.
// Depends on sta_pkg and session_table_with_aging.
`timescale 1ns / 1ps
`default_nettype none

module sta_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic [3:0] slot
);

    // A result is shown only once the sequencer is back in idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // An accepted command always occupies the block for the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // The result of an accepted command does not come too early.
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done ##1 !done)
        else $error("result came too early");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 3'd7))
        else $error("undefined status code");

    // Results that name no slot report slot zero.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == sta_pkg::ST_NOT_FOUND || status == sta_pkg::ST_FULL
                  || status == sta_pkg::ST_SWEPT)) |-> (slot == 4'd0))
        else $error("slot not zero for a slotless status");

endmodule

bind session_table_with_aging sta_checker u_sta_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .slot   (slot)
);

`default_nettype wire

### bench/session_table_checker.sv
// Checker for the session table with aging: tracks the table contents and the timeout,
// predicts the status and slot of every accepted command and compares each done result.
// Depends on sta_pkg.
`timescale 1ns / 1ps

module session_table_checker
    import sta_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  operation,
    input  wire logic [31:0] address_key,
    input  wire logic [31:0] current_time,
    input  wire logic        done,
    input  wire logic [2:0]  status,
    input  wire logic [3:0]  slot,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    output int               mismatches,
    output int               in_flight
);

    typedef struct {
        status_t     st;
        logic [3:0]  sl;
    } session_result_t;

    logic              tbl_valid [ENTRIES];
    logic [KEY_W-1:0]  tbl_key   [ENTRIES];
    logic [TIME_W-1:0] tbl_login [ENTRIES];
    logic [TIME_W-1:0] timeout_q;

    session_result_t   awaited_q [$];
    session_result_t   want;
    int                errors = 0;

    initial begin
        mismatches = 0;
        in_flight  = 0;
    end

    // Age wraps modulo 2^32, so a time that runs backward gives a huge age.
    function automatic bit aged_out(int idx, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = now - tbl_login[idx];
        return !(age < timeout_q);
    endfunction

    // Lowest live match, clearing expired matches below it on the way.
    function automatic int live_slot(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == key) begin
                if (!aged_out(i, now))
                    return i;
                tbl_valid[i] = 1'b0;
            end
        end
        return -1;
    endfunction

    function automatic session_result_t apply_command(op_t op, logic [KEY_W-1:0] key,
                                                      logic [TIME_W-1:0] now);
        session_result_t r;
        int              hit;
        r.st = ST_NOT_FOUND;
        r.sl = '0;
        case (op)
            OP_LOOKUP:
            begin
                hit = live_slot(key, now);
                if (hit >= 0)
                begin
                    r.st = ST_HIT;
                    r.sl = hit[3:0];
                end
            end
            OP_ADD:
            begin
                hit = live_slot(key, now);
                if (hit >= 0)
                begin
                    tbl_login[hit] = now;
                    r.st = ST_REFRESHED;
                    r.sl = hit[3:0];
                end
                else
                begin
                    r.st = ST_FULL;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!tbl_valid[i])
                        begin
                            tbl_valid[i] = 1'b1;
                            tbl_key[i]   = key;
                            tbl_login[i] = now;
                            r.st = ST_INSERTED;
                            r.sl = i[3:0];
                            break;
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                // Remove ignores age: an expired match is still removed.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_key[i] == key)
                    begin
                        tbl_valid[i] = 1'b0;
                        r.st = ST_REMOVED;
                        r.sl = i[3:0];
                        break;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && aged_out(i, now))
                        tbl_valid[i] = 1'b0;
                end
                r.st = ST_SWEPT;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
            end
            timeout_q = TIMEOUT_RESET;
            awaited_q.delete();
            in_flight <= 0;
        end
        else
        begin
            // The result of the previous command is checked before a new command is
            // taken, since both can happen at the same edge.
            if (done)
            begin
                if (awaited_q.size() == 0)
                begin
                    $error("result with no command outstanding: status %0d slot %0d",
                           status, slot);
                    errors++;
                end
                else
                begin
                    want = awaited_q.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", want.st, status);
                        errors++;
                    end
                    if (slot !== want.sl)
                    begin
                        $error("slot mismatch: expected %0d, actual %0d", want.sl, slot);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                timeout_q = cfg_data;
            if (start && !busy)
                awaited_q.push_back(apply_command(op_t'(operation), address_key,
                                                  current_time));
            in_flight  <= awaited_q.size();
            mismatches <= errors;
        end
    end

endmodule

### bench/tb.sv
// Testbench top for session_table_with_aging: clock, reset, command and timeout stimulus,
// and the final verdict. Depends on sta_pkg, the block and session_table_checker.
`timescale 1ns / 1ps

module tb;
    import sta_pkg::*;

    localparam int ENTRIES = 16;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [31:0] address_key;
    logic [31:0] current_time;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  slot;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    int          mismatches;
    int          in_flight;

    bit          gaps_on;
    logic [31:0] session_now;
    logic [31:0] timeout_cur;

    session_table_with_aging #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .address_key(address_key),
        .current_time(current_time),
        .done(done),
        .status(status),
        .slot(slot),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    session_table_checker #(
        .ENTRIES(ENTRIES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .address_key(address_key),
        .current_time(current_time),
        .done(done),
        .status(status),
        .slot(slot),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .in_flight(in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("session_table_with_aging verification failed");
        $finish;
    end

    // Leaves start high on return, so back-to-back commands need no extra edge.
    task automatic issue(op_t op, logic [31:0] key, logic [31:0] stamp);
        if (gaps_on && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        address_key  <= key;
        current_time <= stamp;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (in_flight != 0 || busy);
    endtask

    task automatic set_timeout(logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        timeout_cur = value;
    endtask

    task automatic run_directed();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        issue(OP_LOOKUP, 32'h0000_0000, t0);
        issue(OP_REMOVE, 32'hFFFF_FFFF, t0);
        issue(OP_SWEEP, 32'h0000_0000, t0);
        issue(OP_ADD, 32'h0000_0000, t0);
        issue(OP_ADD, 32'hFFFF_FFFF, t0 + 32'd10);
        // One below the timeout is still live; the refresh time wraps past zero.
        issue(OP_LOOKUP, 32'h0000_0000, t0 + 32'd299);
        issue(OP_ADD, 32'hFFFF_FFFF, t0 + 32'd300);
        issue(OP_LOOKUP, 32'h0000_0000, t0 + 32'd300);
        issue(OP_ADD, 32'h0000_0000, t0 + 32'd300);
        for (int k = 1; k <= ENTRIES - 2; k++) begin
            issue(OP_ADD, 32'h5A5A_0000 | k, t0 + 32'd301);
        end
        issue(OP_ADD, 32'hA5A5_A5A5, t0 + 32'd302);
        issue(OP_REMOVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        issue(OP_SWEEP, 32'h0000_0000, t0 + 32'd601);
        issue(OP_LOOKUP, 32'h5A5A_0001, t0 + 32'd601);
    endtask

    // Commands on a small key pool with a mostly advancing clock, so that entries
    // fill the table, get refreshed and age out under the current timeout.
    task automatic run_random(int count);
        logic [31:0] keys [32];
        int          nkeys;
        int          r;
        logic [31:0] key;
        logic [31:0] span;
        op_t         op;
        nkeys = $urandom_range(6, 32);
        for (int k = 0; k < nkeys; k++) begin
            keys[k] = $urandom;
        end
        span = (timeout_cur == 0 || timeout_cur > 32'd2000) ? 32'd200 : timeout_cur / 4 + 1;
        for (int n = 0; n < count; n++) begin
            r  = $urandom_range(0, 99);
            op = r < 40 ? OP_ADD : r < 65 ? OP_LOOKUP : r < 85 ? OP_REMOVE : OP_SWEEP;
            key = ($urandom_range(0, 9) == 0) ? $urandom : keys[$urandom_range(0, nkeys - 1)];
            r = $urandom_range(0, 99);
            if (r < 4)
                session_now = $urandom;
            else if (r < 9)
                session_now -= $urandom_range(1, 40);
            else
                session_now += $urandom_range(0, span);
            issue(op, key, session_now);
            if ($urandom_range(0, 149) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        operation    <= OP_LOOKUP;
        address_key  <= '0;
        current_time <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        gaps_on      = 1'b1;
        timeout_cur  = TIMEOUT_RESET;
        session_now  = $urandom;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        set_timeout(32'd0);
        run_random(100);
        set_timeout(32'd1);
        run_random(100);
        // A long stretch with no random sender gaps.
        set_timeout(32'd25);
        gaps_on = 1'b0;
        run_random(150);
        gaps_on = 1'b1;
        set_timeout(32'hFFFF_FFFF);
        run_random(120);
        set_timeout($urandom_range(2, 1000));
        run_random(150);
        set_timeout(32'd300);
        run_random(100);
        set_timeout($urandom);
        run_random(100);

        drain();
        repeat (3 * ENTRIES) @(posedge clk);
        if (mismatches == 0)
            $display("session_table_with_aging verification clean");
        else
            $display("session_table_with_aging verification failed");
        $finish;
    end

endmodule
